// ----- src/bank_switch_memory_mapper_defines.svh -----
// Assertion helpers for the bank switch memory mapper.
// Both forms sample on the rising edge of the block clock.
`ifndef BANK_SWITCH_MEMORY_MAPPER_DEFINES_SVH
`define BANK_SWITCH_MEMORY_MAPPER_DEFINES_SVH

// Checked only while the block is out of reset.
`define BSMM_ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, including during reset.
`define BSMM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- src/bsmm_pkg.sv -----
`timescale 1ns / 1ps

package bsmm_pkg;

   // Store that a request reaches.
   typedef enum logic [1:0] {
      TGT_ROM  = 2'd0,
      TGT_CART = 2'd1,
      TGT_SYS  = 2'd2,
      TGT_DROP = 2'd3
   } target_type;

   // Configuration register indexes.
   localparam logic [0:0] CSR_MAPPER_ENABLE = 1'b0;
   localparam logic [0:0] CSR_ROM_SIZE_LOG2 = 1'b1;

   localparam int OFFSET_W   = 22;
   localparam int WINDOW_W   = 14;
   localparam int CSR_DATA_W = 5;

   localparam logic [4:0] ROM_MIN_BITS   = 5'd14;
   localparam logic [4:0] ROM_SIZE_RESET = 5'd22;

   // Bank registers after reset: control, then the three window banks.
   localparam logic [7:0] BANK_RESET [4] = '{8'd0, 8'd0, 8'd1, 8'd2};

   // Control register bits.
   localparam int CTRL_CART_EN   = 3;
   localparam int CTRL_CART_HALF = 2;

endpackage

// ----- src/bank_switch_memory_mapper.sv -----
`timescale 1ns / 1ps
// A request is accepted into the input register and, once the result register is free or
// being emptied, moves into the result register, whose contents drive rsp_*.
// Throughput: one request per cycle while rsp_tready is high; while a result waits, the
// input register takes one more request and then req_tready stays low until it is taken.
// Reset is synchronous and active high: it empties both registers and restores the
// bank registers (0, 0, 1, 2), banked mode and the largest ROM size.
`include "bank_switch_memory_mapper_defines.svh"

module bank_switch_memory_mapper #(
   parameter int ROM_ADDR_BITS  = 22,
   parameter int CART_RAM_BYTES = 32768,
   parameter int SYS_RAM_BYTES  = 8192
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] cpu_address, [23:16] write_data
   input  logic        req_tuser,   // [0] req_type (1 write)
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [21:0] phys_offset, [23:22] zero
   output logic [2:0]  rsp_tuser,   // [1:0] target, [2] store_write
   // configuration
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [bsmm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int OW = bsmm_pkg::OFFSET_W;
   localparam int WW = bsmm_pkg::WINDOW_W;

   localparam logic [4:0]    ROM_MAX_BITS = 5'(ROM_ADDR_BITS);
   localparam logic [OW-1:0] CART_MASK    = OW'(CART_RAM_BYTES - 1);
   localparam logic [OW-1:0] CART_HALF    = OW'(CART_RAM_BYTES / 2);
   localparam logic [OW-1:0] SYS_MASK     = OW'(SYS_RAM_BYTES - 1);

   logic        mapper_enable_ff;
   logic [4:0]  rom_size_log2_ff;
   logic [7:0]  bank_ff [4];

   logic        s1_valid_ff;
   logic        s1_write_ff;
   logic [15:0] s1_addr_ff;
   logic [7:0]  s1_data_ff;
   logic        s1_advance;

   logic                 rsp_valid_ff;
   bsmm_pkg::target_type rsp_target_ff;
   logic [OW-1:0]        rsp_offset_ff;
   logic                 rsp_store_write_ff;

   bsmm_pkg::target_type target_in;
   logic [OW-1:0]        offset_in;
   logic                 store_write_in;

   logic [4:0]    rom_bits;
   logic [OW:0]   rom_mask_wide;
   logic [OW-1:0] rom_mask;
   logic [OW-1:0] addr_ext;
   logic [OW-1:0] window_off;
   logic [OW-1:0] cart_sum;
   logic          reg_window;

   // The held request moves on whenever the result register is free or being emptied.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_offset_ff};
   assign rsp_tuser  = {rsp_store_write_ff, rsp_target_ff};

   assign reg_window = (s1_addr_ff[15:2] == 14'h3FFF);

   // Address decode.
   always_comb begin
      if (rom_size_log2_ff < bsmm_pkg::ROM_MIN_BITS) begin
         rom_bits = bsmm_pkg::ROM_MIN_BITS;
      end else if (rom_size_log2_ff > ROM_MAX_BITS) begin
         rom_bits = ROM_MAX_BITS;
      end else begin
         rom_bits = rom_size_log2_ff;
      end
      rom_mask_wide = ((OW + 1)'(1) << rom_bits) - (OW + 1)'(1);
      rom_mask      = rom_mask_wide[OW-1:0];

      addr_ext   = OW'(s1_addr_ff);
      window_off = OW'(s1_addr_ff[WW-1:0]);
      cart_sum   = (bank_ff[0][bsmm_pkg::CTRL_CART_HALF] ? CART_HALF : '0) + window_off;

      target_in      = bsmm_pkg::TGT_ROM;
      offset_in      = '0;
      store_write_in = 1'b0;

      if (s1_addr_ff[15:14] == 2'b11) begin
         target_in      = bsmm_pkg::TGT_SYS;
         offset_in      = addr_ext & SYS_MASK;
         store_write_in = s1_write_ff;
      end else if (!mapper_enable_ff) begin
         offset_in = addr_ext & rom_mask;
      end else if (s1_addr_ff[15:10] == 6'd0) begin
         // The first kilobyte is fixed to the start of ROM.
         offset_in = addr_ext;
      end else begin
         case (s1_addr_ff[15:14])
            2'b00: offset_in = ({bank_ff[1], {WW{1'b0}}} & rom_mask) | window_off;
            2'b01: offset_in = ({bank_ff[2], {WW{1'b0}}} & rom_mask) | window_off;
            default: begin
               if (bank_ff[0][bsmm_pkg::CTRL_CART_EN]) begin
                  target_in      = bsmm_pkg::TGT_CART;
                  offset_in      = cart_sum & CART_MASK;
                  store_write_in = s1_write_ff;
               end else begin
                  offset_in = ({bank_ff[3], {WW{1'b0}}} & rom_mask) | window_off;
               end
            end
         endcase
      end

      // ROM is never written.
      if (s1_write_ff && target_in == bsmm_pkg::TGT_ROM) begin
         target_in      = bsmm_pkg::TGT_DROP;
         offset_in      = '0;
         store_write_in = 1'b0;
      end
   end

   // Configuration and bank registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mapper_enable_ff <= 1'b1;
         rom_size_log2_ff <= bsmm_pkg::ROM_SIZE_RESET;
         for (int i = 0; i < 4; i++) begin
            bank_ff[i] <= bsmm_pkg::BANK_RESET[i];
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               bsmm_pkg::CSR_MAPPER_ENABLE: mapper_enable_ff <= csr_wdata[0];
               bsmm_pkg::CSR_ROM_SIZE_LOG2: rom_size_log2_ff <= csr_wdata;
               default: ;
            endcase
         end
         // A bank register takes effect for the very next request in the pipe.
         if (s1_advance && s1_write_ff && mapper_enable_ff && reg_window) begin
            bank_ff[s1_addr_ff[1:0]] <= s1_data_ff;
         end
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_write_ff <= req_tuser;
         s1_addr_ff  <= req_tdata[15:0];
         s1_data_ff  <= req_tdata[23:16];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_target_ff      <= target_in;
         rsp_offset_ff      <= offset_in;
         rsp_store_write_ff <= store_write_in;
      end
   end

   `BSMM_ASSERT_RUN(a_held_request_kept, s1_valid_ff && !s1_advance |=> s1_valid_ff, "held request lost")
   `BSMM_ASSERT_RUN(a_rom_no_write, rsp_valid_ff && (rsp_target_ff == bsmm_pkg::TGT_ROM || rsp_target_ff == bsmm_pkg::TGT_DROP) |-> !rsp_store_write_ff, "write strobe on ROM or dropped access")
   `BSMM_ASSERT_RUN(a_bank_load, s1_advance && s1_write_ff && mapper_enable_ff && reg_window |=> bank_ff[$past(s1_addr_ff[1:0])] == $past(s1_data_ff), "bank register not loaded")
   `BSMM_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid_ff && !s1_valid_ff, "pipeline not empty after reset")

endmodule
